>>> sv/midi_track_event_parser_core_assert.svh
// Assertion macros for the track event parser
`ifndef MIDI_TRACK_EVENT_PARSER_CORE_ASSERT_SVH
`define MIDI_TRACK_EVENT_PARSER_CORE_ASSERT_SVH

// Property that must hold on every edge out of reset
`define MTEP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition on one edge implies a consequence on the next edge
`define MTEP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/mtep_pkg.sv
// Types and constants of the track event parser
package mtep_pkg;

  localparam int unsigned MAX_QUANTITY_BYTES = 4;
  localparam int unsigned QCNT_W = (MAX_QUANTITY_BYTES > 1) ? $clog2(MAX_QUANTITY_BYTES) : 1;
  localparam int unsigned Q_W = 28;

  localparam logic [7:0] STATUS_META   = 8'hFF;
  localparam logic [7:0] STATUS_SYSTEM = 8'hF0;
  localparam logic [3:0] KIND_PROGRAM  = 4'hC;
  localparam logic [3:0] KIND_ATOUCH   = 4'hD;

  typedef enum logic [2:0] {
    PH_DELTA,
    PH_STATUS,
    PH_DATA1,
    PH_DATA2,
    PH_META_TYPE,
    PH_META_LEN,
    PH_PAYLOAD,
    PH_DISCARD
  } phase_e;

  typedef enum logic [1:0] {
    RT_CHANNEL,
    RT_META,
    RT_PAYLOAD,
    RT_ERROR
  } rtype_e;

  typedef enum logic [1:0] {
    EC_TRUNCATED,
    EC_UNSUPPORTED,
    EC_NO_RUNNING,
    EC_TOO_LONG
  } ecode_e;

  typedef struct packed {
    phase_e            phase;
    logic [Q_W-1:0]    acc;
    logic [QCNT_W-1:0] cnt;
    logic [Q_W-1:0]    held_delta;
    logic [7:0]        run_status;
    logic [6:0]        held_d1;
    logic [7:0]        held_mtype;
    logic [Q_W-1:0]    remain;
  } state_t;

  typedef struct packed {
    rtype_e         rtype;
    logic [Q_W-1:0] delta;
    logic [7:0]     status;
    logic [6:0]     d1;
    logic [6:0]     d2;
    logic [7:0]     mtype;
    logic [Q_W-1:0] mlen;
    logic [7:0]     pbyte;
    logic           plast;
    ecode_e         ecode;
  } result_t;

  localparam state_t ST_RESET = '{phase: PH_DELTA, default: '0};

endpackage

>>> sv/mtep_intf.sv
// Byte input and event output channel interfaces
interface mtep_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       chunk_end;

  modport source (output valid, output data_byte, output chunk_end, input ready);
  modport sink (input valid, input data_byte, input chunk_end, output ready);
endinterface

interface mtep_out_if;
  logic                    valid;
  logic                    ready;
  logic [1:0]              result_type;
  logic [mtep_pkg::Q_W-1:0] delta_time;
  logic [7:0]              status_byte;
  logic [6:0]              first_data;
  logic [6:0]              second_data;
  logic [7:0]              meta_type;
  logic [mtep_pkg::Q_W-1:0] meta_length;
  logic [7:0]              payload_byte;
  logic                    payload_last;
  logic [1:0]              error_code;

  modport source (
    output valid, output result_type, output delta_time, output status_byte,
    output first_data, output second_data, output meta_type, output meta_length,
    output payload_byte, output payload_last, output error_code, input ready
  );
  modport sink (
    input valid, input result_type, input delta_time, input status_byte,
    input first_data, input second_data, input meta_type, input meta_length,
    input payload_byte, input payload_last, input error_code, output ready
  );
endinterface

>>> sv/mtep_step.sv
// Per-byte parse step: next parser state and the result a byte produces
module mtep_step (
  input  mtep_pkg::state_t  st_i,
  input  logic [7:0]        byte_i,
  input  logic              last_i,
  output mtep_pkg::state_t  st_o,
  output mtep_pkg::result_t res_o,
  output logic              res_vld_o
);
  import mtep_pkg::*;

  logic [Q_W-1:0]  q_acc;
  logic [QCNT_W:0] q_inc;
  logic            q_long;
  logic [Q_W-1:0]  remain_dec;
  logic            emitted, complete, err, discard;

  assign q_acc      = {st_i.acc[Q_W-8:0], byte_i[6:0]};
  assign q_inc      = {1'b0, st_i.cnt} + (QCNT_W+1)'(1);
  assign q_long     = q_inc >= (QCNT_W+1)'(MAX_QUANTITY_BYTES);
  assign remain_dec = st_i.remain - Q_W'(1);

  always_comb begin
    st_o     = st_i;
    res_o    = '0;
    emitted  = 1'b0;
    complete = 1'b0;
    err      = 1'b0;
    discard  = 1'b0;

    unique case (st_i.phase)
      PH_DELTA: begin
        st_o.acc = q_acc;
        if (byte_i[7]) begin
          if (q_long) begin
            err         = 1'b1;
            res_o.rtype = RT_ERROR;
            res_o.ecode = EC_TOO_LONG;
            st_o.phase  = PH_DISCARD;
          end else begin
            st_o.cnt = q_inc[QCNT_W-1:0];
          end
        end else begin
          st_o.cnt        = '0;
          st_o.held_delta = q_acc;
          st_o.acc        = '0;
          st_o.phase      = PH_STATUS;
        end
      end
      PH_STATUS, PH_DATA1: begin
        if (st_i.phase == PH_STATUS && byte_i == STATUS_META) begin
          st_o.run_status = '0;
          st_o.phase      = PH_META_TYPE;
        end else if (st_i.phase == PH_STATUS && byte_i >= STATUS_SYSTEM) begin
          err         = 1'b1;
          res_o.rtype = RT_ERROR;
          res_o.ecode = EC_UNSUPPORTED;
          st_o.phase  = PH_DISCARD;
        end else if (st_i.phase == PH_STATUS && byte_i[7]) begin
          st_o.run_status = byte_i;
          st_o.phase      = PH_DATA1;
        end else if (st_i.phase == PH_STATUS && st_i.run_status == '0) begin
          err         = 1'b1;
          res_o.rtype = RT_ERROR;
          res_o.ecode = EC_NO_RUNNING;
          st_o.phase  = PH_DISCARD;
        end else if (st_i.run_status[7:4] == KIND_PROGRAM ||
                     st_i.run_status[7:4] == KIND_ATOUCH) begin
          // one-data-byte message completes here
          emitted      = 1'b1;
          complete     = 1'b1;
          res_o.rtype  = RT_CHANNEL;
          res_o.delta  = st_i.held_delta;
          res_o.status = st_i.run_status;
          res_o.d1     = byte_i[6:0];
          st_o.phase   = PH_DELTA;
        end else begin
          st_o.held_d1 = byte_i[6:0];
          st_o.phase   = PH_DATA2;
        end
      end
      PH_DATA2: begin
        emitted      = 1'b1;
        complete     = 1'b1;
        res_o.rtype  = RT_CHANNEL;
        res_o.delta  = st_i.held_delta;
        res_o.status = st_i.run_status;
        res_o.d1     = st_i.held_d1;
        res_o.d2     = byte_i[6:0];
        st_o.phase   = PH_DELTA;
      end
      PH_META_TYPE: begin
        st_o.held_mtype = byte_i;
        st_o.acc        = '0;
        st_o.cnt        = '0;
        st_o.phase      = PH_META_LEN;
      end
      PH_META_LEN: begin
        st_o.acc = q_acc;
        if (byte_i[7]) begin
          if (q_long) begin
            err         = 1'b1;
            res_o.rtype = RT_ERROR;
            res_o.ecode = EC_TOO_LONG;
            st_o.phase  = PH_DISCARD;
          end else begin
            st_o.cnt = q_inc[QCNT_W-1:0];
          end
        end else begin
          st_o.cnt    = '0;
          st_o.remain = q_acc;
          st_o.acc    = '0;
          emitted     = 1'b1;
          res_o.rtype = RT_META;
          res_o.delta = st_i.held_delta;
          res_o.mtype = st_i.held_mtype;
          res_o.mlen  = q_acc;
          if (q_acc == '0) begin
            complete   = 1'b1;
            st_o.phase = PH_DELTA;
          end else begin
            st_o.phase = PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        st_o.remain = remain_dec;
        emitted     = 1'b1;
        res_o.rtype = RT_PAYLOAD;
        res_o.delta = st_i.held_delta;
        res_o.mtype = st_i.held_mtype;
        res_o.pbyte = byte_i;
        res_o.plast = (remain_dec == '0);
        if (remain_dec == '0) begin
          complete   = 1'b1;
          st_o.phase = PH_DELTA;
        end
      end
      PH_DISCARD: begin
        discard = 1'b1;
      end
    endcase

    // chunk end: an unfinished event becomes a truncation error
    if (last_i) begin
      if (!discard && !err && !complete) begin
        res_o       = '0;
        res_o.rtype = RT_ERROR;
        res_o.ecode = EC_TRUNCATED;
        err         = 1'b1;
      end
      st_o = ST_RESET;
    end

    res_vld_o = !discard && (emitted || err);
  end

endmodule

>>> sv/midi_track_event_parser_core.sv
// Track chunk event parser top level: input register, parse step, result register
//
//   channel  dir  contents
//   trk_i    in   data_byte, chunk_end
//   evt_o    out  result_type, delta_time, status_byte, first_data, second_data,
//                 meta_type, meta_length, payload_byte, payload_last, error_code
//
// One byte per cycle unless stalled; a result is loaded from the input register
// once the result register is free. The parse step between them sets the rate.
// Reset returns the parser to the delta-time phase with running status cleared.
// A stalled result holds the input register; a byte giving no result still
// waits for a free result register.
module midi_track_event_parser_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  mtep_in_if.sink          trk_i,
  mtep_out_if.source       evt_o
);
  import mtep_pkg::*;

  logic       in_vld_q, in_vld_d;
  logic [7:0] in_byte_q;
  logic       in_last_q;
  state_t     st_q, st_nxt;
  result_t    res, out_q;
  logic       res_vld;
  logic       out_vld_q, out_vld_d;
  logic       out_free, advance, take;

  assign out_free    = !out_vld_q || evt_o.ready;
  assign advance     = in_vld_q && out_free;
  assign trk_i.ready = !in_vld_q || out_free;
  assign take        = trk_i.valid && trk_i.ready;

  assign in_vld_d  = take ? 1'b1 : (advance ? 1'b0 : in_vld_q);
  assign out_vld_d = out_free ? (advance && res_vld) : 1'b1;

  mtep_step u_step (
    .st_i     (st_q),
    .byte_i   (in_byte_q),
    .last_i   (in_last_q),
    .st_o     (st_nxt),
    .res_o    (res),
    .res_vld_o(res_vld)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      st_q      <= ST_RESET;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
      if (advance) begin
        st_q <= st_nxt;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      in_byte_q <= trk_i.data_byte;
      in_last_q <= trk_i.chunk_end;
    end
    if (advance && res_vld) begin
      out_q <= res;
    end
  end

  assign evt_o.valid        = out_vld_q;
  assign evt_o.result_type  = out_q.rtype;
  assign evt_o.delta_time   = out_q.delta;
  assign evt_o.status_byte  = out_q.status;
  assign evt_o.first_data   = out_q.d1;
  assign evt_o.second_data  = out_q.d2;
  assign evt_o.meta_type    = out_q.mtype;
  assign evt_o.meta_length  = out_q.mlen;
  assign evt_o.payload_byte = out_q.pbyte;
  assign evt_o.payload_last = out_q.plast;
  assign evt_o.error_code   = out_q.ecode;

  `include "midi_track_event_parser_core_assert.svh"

  `MTEP_ASSERT_NEXT(a_state_held_on_stall, in_vld_q && !out_free, $stable(st_q), "parser state moved while stalled")
  `MTEP_ASSERT_NEXT(a_chunk_end_resets, advance && in_last_q, st_q == ST_RESET, "chunk end did not reset the parser")
  `MTEP_ASSERT(a_discard_silent, !(advance && st_q.phase == PH_DISCARD && res_vld), "result produced while discarding")

endmodule

>>> sim/midi_track_event_parser_core_checker.sv
`timescale 1ns / 1ps
// Checker for the track event parser: follows both channels, predicts each event and compares
module midi_track_event_parser_core_checker (
  input  logic clk_i,
  input  logic rst_ni,
  mtep_in_if   trk_i,
  mtep_out_if  evt_i,
  output int   err_cnt_o,
  output int   pending_o,
  output int   checked_o
);
  import mtep_pkg::*;

  typedef enum logic [1:0] {
    QTY_MORE,
    QTY_DONE,
    QTY_LONG
  } qty_e;

  // parser state as the block should hold it
  phase_e         phase;
  logic [Q_W-1:0] qacc;
  int unsigned    qbytes;
  logic [Q_W-1:0] delta_hold;
  logic [7:0]     run_stat;
  logic [6:0]     d1_hold;
  logic [7:0]     mtype_hold;
  logic [Q_W-1:0] pay_left;

  result_t events_due[$];
  int      errs = 0;
  int      due_cnt = 0;
  int      checked = 0;

  assign err_cnt_o = errs;
  assign pending_o = due_cnt;
  assign checked_o = checked;

  function automatic void clear_parser();
    phase      = PH_DELTA;
    qacc       = '0;
    qbytes     = 0;
    delta_hold = '0;
    run_stat   = '0;
    d1_hold    = '0;
    mtype_hold = '0;
    pay_left   = '0;
  endfunction

  // one byte of a variable-length quantity, seven bits at a time
  function automatic qty_e take_qty(input logic [7:0] b);
    qacc = {qacc[Q_W-8:0], b[6:0]};
    if (b[7]) begin
      if (qbytes + 1 >= MAX_QUANTITY_BYTES) return QTY_LONG;
      qbytes++;
      return QTY_MORE;
    end
    qbytes = 0;
    return QTY_DONE;
  endfunction

  function automatic result_t flag_error(input ecode_e code);
    result_t r;
    r       = '0;
    r.rtype = RT_ERROR;
    r.ecode = code;
    phase   = PH_DISCARD;
    return r;
  endfunction

  function automatic result_t channel_event(input logic [6:0] d1, input logic [6:0] d2);
    result_t r;
    r        = '0;
    r.rtype  = RT_CHANNEL;
    r.delta  = delta_hold;
    r.status = run_stat;
    r.d1     = d1;
    r.d2     = d2;
    phase    = PH_DELTA;
    return r;
  endfunction

  // program change and channel aftertouch finish on their first data byte
  function automatic bit take_first(input logic [7:0] b, inout result_t r);
    if (run_stat[7:4] == KIND_PROGRAM || run_stat[7:4] == KIND_ATOUCH) begin
      r = channel_event(b[6:0], 7'd0);
      return 1'b1;
    end
    d1_hold = b[6:0];
    phase   = PH_DATA2;
    return 1'b0;
  endfunction

  // advances the parser by one byte; returns 1 when the byte yields an event
  function automatic bit parse_byte(input logic [7:0] b, input logic last, output result_t r);
    qty_e q;
    bit   done;
    bit   fail;
    bit   emit;
    r    = '0;
    done = 1'b0;
    fail = 1'b0;
    emit = 1'b0;
    case (phase)
      PH_DELTA: begin
        q = take_qty(b);
        if (q == QTY_LONG) begin
          r    = flag_error(EC_TOO_LONG);
          fail = 1'b1;
        end else if (q == QTY_DONE) begin
          delta_hold = qacc;
          qacc       = '0;
          phase      = PH_STATUS;
        end
      end
      PH_STATUS: begin
        if (b == STATUS_META) begin
          run_stat = '0;
          phase    = PH_META_TYPE;
        end else if (b >= STATUS_SYSTEM) begin
          r    = flag_error(EC_UNSUPPORTED);
          fail = 1'b1;
        end else if (b[7]) begin
          run_stat = b;
          phase    = PH_DATA1;
        end else if (run_stat == '0) begin
          r    = flag_error(EC_NO_RUNNING);
          fail = 1'b1;
        end else begin
          done = take_first(b, r);
          emit = done;
        end
      end
      PH_DATA1: begin
        done = take_first(b, r);
        emit = done;
      end
      PH_DATA2: begin
        r    = channel_event(d1_hold, b[6:0]);
        emit = 1'b1;
        done = 1'b1;
      end
      PH_META_TYPE: begin
        mtype_hold = b;
        qacc       = '0;
        qbytes     = 0;
        phase      = PH_META_LEN;
      end
      PH_META_LEN: begin
        q = take_qty(b);
        if (q == QTY_LONG) begin
          r    = flag_error(EC_TOO_LONG);
          fail = 1'b1;
        end else if (q == QTY_DONE) begin
          pay_left = qacc;
          qacc     = '0;
          r.rtype  = RT_META;
          r.delta  = delta_hold;
          r.mtype  = mtype_hold;
          r.mlen   = pay_left;
          emit     = 1'b1;
          if (pay_left == '0) begin
            phase = PH_DELTA;
            done  = 1'b1;
          end else begin
            phase = PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        pay_left = pay_left - 1'b1;
        r.rtype  = RT_PAYLOAD;
        r.delta  = delta_hold;
        r.mtype  = mtype_hold;
        r.pbyte  = b;
        r.plast  = (pay_left == '0);
        emit     = 1'b1;
        if (pay_left == '0) begin
          phase = PH_DELTA;
          done  = 1'b1;
        end
      end
      default: begin
        // skipping the rest of a chunk after an error
        if (last) clear_parser();
        return 1'b0;
      end
    endcase
    if (last) begin
      if (!fail && !done) begin
        r    = flag_error(EC_TRUNCATED);
        fail = 1'b1;
      end
      clear_parser();
    end
    return emit || fail;
  endfunction

  function automatic void check_field(input string name, input logic [Q_W-1:0] exp_v,
                                      input logic [Q_W-1:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
      errs++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    result_t want;
    if (!rst_ni) begin
      clear_parser();
      events_due.delete();
    end else begin
      if (trk_i.valid && trk_i.ready) begin
        if (parse_byte(trk_i.data_byte, trk_i.chunk_end, want)) events_due.push_back(want);
      end
      if (evt_i.valid && evt_i.ready) begin
        if (events_due.size() == 0) begin
          $error("unexpected event transfer: result_type %0d", evt_i.result_type);
          errs++;
        end else begin
          want = events_due.pop_front();
          check_field("result_type", Q_W'(want.rtype), Q_W'(evt_i.result_type));
          check_field("delta_time", want.delta, evt_i.delta_time);
          check_field("status_byte", Q_W'(want.status), Q_W'(evt_i.status_byte));
          check_field("first_data", Q_W'(want.d1), Q_W'(evt_i.first_data));
          check_field("second_data", Q_W'(want.d2), Q_W'(evt_i.second_data));
          check_field("meta_type", Q_W'(want.mtype), Q_W'(evt_i.meta_type));
          check_field("meta_length", want.mlen, evt_i.meta_length);
          check_field("payload_byte", Q_W'(want.pbyte), Q_W'(evt_i.payload_byte));
          check_field("payload_last", Q_W'(want.plast), Q_W'(evt_i.payload_last));
          check_field("error_code", Q_W'(want.ecode), Q_W'(evt_i.error_code));
          checked++;
        end
      end
    end
    due_cnt = events_due.size();
  end

endmodule

>>> sim/midi_track_event_parser_core_test.sv
`timescale 1ns / 1ps
// Testbench top for the track event parser: clock, reset, chunk stimulus and verdict
module midi_track_event_parser_core_test;
  import mtep_pkg::*;

  localparam int BYTES_PER_PHASE = 420;
  localparam int HOLD_CYCLES     = 300;
  localparam int DRAIN_CYCLES    = 20;

  logic clk = 1'b0;
  logic rst_n;

  mtep_in_if  trk ();
  mtep_out_if evt ();

  int err_cnt;
  int pending;
  int checked;

  int snd_idle = 0;
  int rcv_idle = 0;
  bit rcv_hold = 1'b0;
  int n_bytes  = 0;
  int n_chunks = 0;

  logic [7:0] chunk_q[$];

  always #5 clk = ~clk;

  midi_track_event_parser_core dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .trk_i  (trk),
    .evt_o  (evt)
  );

  midi_track_event_parser_core_checker checker_i (
    .clk_i     (clk),
    .rst_ni    (rst_n),
    .trk_i     (trk),
    .evt_i     (evt),
    .err_cnt_o (err_cnt),
    .pending_o (pending),
    .checked_o (checked)
  );

  // entered and left at a falling edge; valid stays high between back-to-back transfers
  task automatic send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < snd_idle) begin
      trk.valid <= 1'b0;
      @(negedge clk);
    end
    trk.valid     <= 1'b1;
    trk.data_byte <= b;
    trk.chunk_end <= last;
    @(posedge clk);
    while (!trk.ready) @(posedge clk);
    @(negedge clk);
    n_bytes++;
  endtask

  task automatic send_chunk();
    for (int i = 0; i < chunk_q.size(); i++) send_byte(chunk_q[i], i == chunk_q.size() - 1);
    n_chunks++;
  endtask

  task automatic push_qty(input int unsigned v, input int n);
    for (int i = n - 1; i >= 0; i--) chunk_q.push_back({i > 0, 7'(v >> (7 * i))});
  endtask

  function automatic int pick_len();
    int k;
    k = $urandom_range(99);
    if (k < 60) return 1;
    if (k < 80) return 2;
    if (k < 92) return 3;
    return 4;
  endfunction

  task automatic push_rand_qty();
    int n;
    int unsigned v;
    n = pick_len();
    if ($urandom_range(99) < 20) v = $urandom_range(0, 3);
    else v = $urandom() & ((32'd1 << (7 * n)) - 1);
    push_qty(v, n);
  endtask

  function automatic logic [7:0] rand_data();
    if ($urandom_range(99) < 90) return 8'($urandom_range(0, 127));
    return 8'($urandom_range(128, 255));
  endfunction

  task automatic push_data(input logic [7:0] status, input logic [7:0] first);
    chunk_q.push_back(first);
    if (status[7:4] != KIND_PROGRAM && status[7:4] != KIND_ATOUCH) chunk_q.push_back(rand_data());
  endtask

  // mostly well-formed event runs, the rest malformed chunks
  task automatic make_chunk();
    int          nev;
    int          k;
    int          n;
    int unsigned len;
    logic [7:0]  s;
    logic [7:0]  rs;
    bit          cut;
    chunk_q.delete();
    rs  = 8'h00;
    cut = 1'b0;
    if ($urandom_range(99) < 80) begin
      nev = $urandom_range(1, 6);
      for (int e = 0; e < nev && !cut; e++) begin
        push_rand_qty();
        k = $urandom_range(99);
        if (k < 45 || (k < 65 && rs == 8'h00)) begin
          s  = 8'($urandom_range(8'h80, 8'hEF));
          rs = s;
          chunk_q.push_back(s);
          push_data(s, rand_data());
        end else if (k < 65) begin
          push_data(rs, 8'($urandom_range(0, 127)));
        end else if (k < 95) begin
          chunk_q.push_back(STATUS_META);
          chunk_q.push_back(8'($urandom));
          rs = 8'h00;
          if ($urandom_range(99) < 8) begin
            // long payload cut short by the chunk end
            len = $urandom_range(128, 32'h0FFF_FFFF);
            n   = 1;
            while ((len >> (7 * n)) != 0) n++;
            push_qty(len, n);
            repeat ($urandom_range(1, 3)) chunk_q.push_back(8'($urandom));
            cut = 1'b1;
          end else begin
            len = $urandom_range(0, 6);
            push_qty(len, pick_len());
            repeat (len) chunk_q.push_back(8'($urandom));
          end
        end else begin
          chunk_q.push_back(8'($urandom));
        end
      end
      if (!cut && $urandom_range(99) < 10) begin
        k = $urandom_range(1, chunk_q.size() - 1);
        while (chunk_q.size() > k) void'(chunk_q.pop_back());
      end
    end else begin
      k = $urandom_range(99);
      if (k < 25) begin
        repeat ($urandom_range(1, 8)) chunk_q.push_back(8'($urandom));
      end else if (k < 50) begin
        push_rand_qty();
        chunk_q.push_back(8'($urandom_range(8'hF0, 8'hFE)));
        repeat ($urandom_range(0, 3)) chunk_q.push_back(8'($urandom));
      end else if (k < 75) begin
        // over-long quantity, as delta or as meta length
        if ($urandom_range(1)) begin
          push_rand_qty();
          chunk_q.push_back(STATUS_META);
          chunk_q.push_back(8'($urandom));
        end
        repeat ($urandom_range(4, 6)) chunk_q.push_back(8'($urandom_range(128, 255)));
        repeat ($urandom_range(0, 2)) chunk_q.push_back(8'($urandom));
      end else begin
        push_rand_qty();
        chunk_q.push_back(8'($urandom_range(0, 127)));
        repeat ($urandom_range(0, 3)) chunk_q.push_back(8'($urandom));
      end
    end
  endtask

  // receiver: random stalls, or one long hold-off when asked
  initial begin
    evt.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rcv_hold) begin
        evt.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        rcv_hold = 1'b0;
      end
      evt.ready <= ($urandom_range(99) >= rcv_idle);
    end
  end

  initial begin
    int phase_start;
    trk.valid     = 1'b0;
    trk.data_byte = 8'h00;
    trk.chunk_end = 1'b0;
    rst_n         = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // max delta, note with running status, one-byte message with a status-like data
    // byte, meta with a single payload byte
    chunk_q = {8'hFF, 8'hFF, 8'hFF, 8'h7F, 8'h9F, 8'h00, 8'h7F, 8'h00, 8'h7F, 8'h40,
               8'h00, 8'hCF, 8'h85, 8'h00, 8'hFF, 8'h01, 8'h01, 8'hC1};
    send_chunk();
    // meta clears running status, so bare data afterwards is refused
    chunk_q = {8'h00, 8'hFF, 8'h2F, 8'h00, 8'h00, 8'h45};
    send_chunk();
    chunk_q = {8'h80, 8'h80, 8'h80, 8'h80};
    send_chunk();
    chunk_q = {8'h00, 8'hF7};
    send_chunk();
    chunk_q = {8'h00, 8'hB0};
    send_chunk();

    for (int ph = 0; ph < 3; ph++) begin
      trk.valid <= 1'b0;
      wait (pending == 0);
      @(negedge clk);
      snd_idle = (ph == 0) ? 22 : (ph == 1) ? 47 : 0;
      rcv_idle = (ph == 0) ? 47 : (ph == 1) ? 22 : 0;
      if (ph == 2) rcv_hold = 1'b1;
      phase_start = n_bytes;
      while (n_bytes - phase_start < BYTES_PER_PHASE) begin
        make_chunk();
        send_chunk();
      end
    end

    trk.valid <= 1'b0;
    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Drove %0d bytes in %0d track chunks under three stall patterns.", n_bytes,
             n_chunks);
    $display("Compared %0d parser events field by field.", checked);
    if (err_cnt == 0 && pending == 0) begin
      $display("midi_track_event_parser_core_test: clean");
    end else begin
      $display("midi_track_event_parser_core_test: errors");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("Timed out with %0d events still due.", pending);
    $display("midi_track_event_parser_core_test: errors");
    $finish;
  end

endmodule

>>> filelist.f
+incdir+sv
sv/mtep_pkg.sv
sv/mtep_intf.sv
sv/mtep_step.sv
sv/midi_track_event_parser_core.sv
sim/midi_track_event_parser_core_checker.sv
sim/midi_track_event_parser_core_test.sv
